// ----- rtl/chbd_pkg.sv -----
// ----------------------------------------------------------------------------
// Canonical Huffman bit decoder package
// Operation and status codes shared by the decoder and its users.
// ----------------------------------------------------------------------------
`default_nettype none

package chbd_pkg;

	localparam int OP_W     = 2;
	localparam int STATUS_W = 3;
	localparam int SYM_W    = 8;
	localparam int LEN_W    = 5;

	typedef logic [OP_W-1:0]     op_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [SYM_W-1:0]    sym_t;

	localparam op_t OP_ADD     = 2'd0;
	localparam op_t OP_DECODE  = 2'd1;
	localparam op_t OP_CLEAR   = 2'd2;
	localparam op_t OP_RESTART = 2'd3;

	localparam status_t ST_PENDING = 3'd0;
	localparam status_t ST_SYMBOL  = 3'd1;
	localparam status_t ST_ERROR   = 3'd2;
	localparam status_t ST_ADD_OK  = 3'd3;
	localparam status_t ST_ADD_BAD = 3'd4;

endpackage

`default_nettype wire

// ----- rtl/chbd_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// Simple dual-port RAM, one write port and one read port with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module chbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/canonical_huffman_bit_decoder.sv -----
// ----------------------------------------------------------------------------
// Canonical Huffman bit decoder
// Builds a canonical code table from add beats and decodes one bit per beat.
// ----------------------------------------------------------------------------
// Usage:
// Each slave beat carries one operation in s_axis_tuser: add a symbol with a
// code length, decode one coded bit, clear the table, or restart at the root.
// Every input beat produces exactly one master beat with a status in
// m_axis_tuser and the decoded symbol in m_axis_tdata (zero unless a symbol
// was decoded). Symbols take the leftmost free code of their length, so adds
// must come in non-decreasing length order; an out-of-order or overfull add
// is rejected and leaves the table unchanged.
// Throughput is one beat per cycle while the receiver keeps up. From acceptance
// a beat passes through the input register, where the table lookup and state
// update happen and the symbol RAM read is issued, then the result register,
// which also holds the registered RAM read data.
// When the receiver stalls, the result register holds and the input register
// keeps one more beat; s_axis_tready drops only when both are full.
// Reset empties the table and returns the decoder to the root. The symbol
// RAM needs no clearing since only written entries can be reached.
// ----------------------------------------------------------------------------
`default_nettype none

module canonical_huffman_bit_decoder
	import chbd_pkg::*;
#(
	parameter int MAX_CODE_LENGTH = 16,
	parameter int MAX_SYMBOLS     = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// [4:0] code_length, [12:5] symbol_in, [13] bit_req, [15:14] zero
	input  wire logic [15:0] s_axis_tdata,
	// [1:0] op
	input  wire logic [1:0]  s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [7:0] symbol_out
	output logic [7:0]       m_axis_tdata,
	// [2:0] status
	output logic [2:0]       m_axis_tuser
);

	localparam int L  = MAX_CODE_LENGTH;
	localparam int N  = MAX_SYMBOLS;
	localparam int LW = $clog2(L + 1);
	localparam int KW = (L > 1) ? $clog2(L) : 1;
	localparam int SW = $clog2(N + 1);
	localparam int AW = $clog2(N);
	localparam int CW = (L > SW) ? L : SW;

	// Input register.
	logic             vld_s1;
	op_t              op_s1;
	logic [LEN_W-1:0] len_s1;
	sym_t             sym_s1;
	logic             bit_s1;

	// Result register.
	logic             vld_s2;
	status_t          status_s2;

	// Table and decoder state.
	logic [L:0]    next_code_q;
	logic [LW-1:0] last_length_q;
	logic [L-1:0]  first_code_q [L];
	logic [SW-1:0] code_count_q [L];
	logic [AW-1:0] first_index_q [L];
	logic [SW-1:0] symbol_total_q;
	logic [L-1:0]  prefix_q;
	logic [LW-1:0] decode_length_q;

	logic s2_ready;
	logic s1_fire;
	logic s_fire;

	assign s2_ready      = !vld_s2 || m_axis_tready;
	assign s1_fire       = vld_s1 && s2_ready;
	assign s_axis_tready = !vld_s1 || s2_ready;
	assign s_fire        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_fire) begin
			vld_s1 <= 1'b1;
		end else if (s1_fire) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			op_s1  <= op_t'(s_axis_tuser);
			len_s1 <= s_axis_tdata[4:0];
			sym_s1 <= s_axis_tdata[12:5];
			bit_s1 <= s_axis_tdata[13];
		end
	end

	// Lookup and update logic for the item in the input register.
	logic          len_ok;
	logic [LW-1:0] len_w;
	logic [KW-1:0] k_sel;
	logic [L-1:0]  fc_k;
	logic [SW-1:0] cc_k;
	logic [AW-1:0] fi_k;
	logic [LW-1:0] add_shift;
	logic [L:0]    add_code;
	logic          add_ok;
	logic [L-1:0]  prefix_n;
	logic [LW-1:0] d_n;
	logic [L-1:0]  off;
	logic          hit;
	logic [LW-1:0] pend_shift;
	logic [L:0]    pend_code;
	logic          pend;
	logic          dec_err_early;
	logic [AW-1:0] rd_idx;
	status_t       status_c;

	always_comb begin
		len_ok    = (len_s1 != '0) && (32'(len_s1) <= 32'(L));
		len_w     = LW'(len_s1);
		k_sel     = (op_s1 == OP_ADD) ? KW'(len_w - LW'(1)) : KW'(decode_length_q);
		fc_k      = first_code_q[k_sel];
		cc_k      = code_count_q[k_sel];
		fi_k      = first_index_q[k_sel];

		add_shift = len_w - last_length_q;
		add_code  = next_code_q << add_shift;
		add_ok    = len_ok && (len_w >= last_length_q)
			&& (symbol_total_q < SW'(N)) && ((add_code >> len_w) == '0);

		dec_err_early = (symbol_total_q == '0) || (decode_length_q >= LW'(L));
		prefix_n   = L'({prefix_q, bit_s1});
		d_n        = decode_length_q + LW'(1);
		off        = prefix_n - fc_k;
		hit        = (cc_k != '0) && (prefix_n >= fc_k) && (CW'(off) < CW'(cc_k));
		pend_shift = last_length_q - d_n;
		pend_code  = {1'b0, prefix_n} << pend_shift;
		pend       = (d_n < last_length_q) && (pend_code < next_code_q);
		rd_idx     = fi_k + AW'(off);

		case (op_s1)
			OP_ADD: begin
				status_c = add_ok ? ST_ADD_OK : ST_ADD_BAD;
			end
			OP_DECODE: begin
				if (dec_err_early) begin
					status_c = ST_ERROR;
				end else if (hit) begin
					status_c = ST_SYMBOL;
				end else if (pend) begin
					status_c = ST_PENDING;
				end else begin
					status_c = ST_ERROR;
				end
			end
			default: begin
				status_c = ST_PENDING;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_code_q     <= '0;
			last_length_q   <= '0;
			symbol_total_q  <= '0;
			prefix_q        <= '0;
			decode_length_q <= '0;
			for (int i = 0; i < L; i++) begin
				first_code_q[i]  <= '0;
				code_count_q[i]  <= '0;
				first_index_q[i] <= '0;
			end
		end else if (s1_fire) begin
			case (op_s1)
				OP_ADD: begin
					if (add_ok) begin
						if (cc_k == '0) begin
							first_code_q[k_sel]  <= L'(add_code);
							first_index_q[k_sel] <= AW'(symbol_total_q);
						end
						code_count_q[k_sel] <= cc_k + SW'(1);
						symbol_total_q      <= symbol_total_q + SW'(1);
						next_code_q         <= add_code + (L+1)'(1);
						last_length_q       <= len_w;
					end
				end
				OP_DECODE: begin
					if (status_c == ST_PENDING) begin
						prefix_q        <= prefix_n;
						decode_length_q <= d_n;
					end else begin
						prefix_q        <= '0;
						decode_length_q <= '0;
					end
				end
				OP_CLEAR: begin
					next_code_q     <= '0;
					last_length_q   <= '0;
					symbol_total_q  <= '0;
					prefix_q        <= '0;
					decode_length_q <= '0;
					for (int i = 0; i < L; i++) begin
						first_code_q[i]  <= '0;
						code_count_q[i]  <= '0;
						first_index_q[i] <= '0;
					end
				end
				default: begin
					prefix_q        <= '0;
					decode_length_q <= '0;
				end
			endcase
		end
	end

	// The RAM read register only loads together with the result register, so
	// a stalled result keeps its symbol.
	logic ram_we;
	logic ram_re;
	sym_t ram_rdata;

	assign ram_we = s1_fire && (op_s1 == OP_ADD) && add_ok;
	assign ram_re = s1_fire && (status_c == ST_SYMBOL);

	chbd_ram #(
		.WIDTH (SYM_W),
		.DEPTH (N)
	) u_symbol_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(symbol_total_q)),
		.wdata (sym_s1),
		.re    (ram_re),
		.raddr (rd_idx),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (s1_fire) begin
			vld_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			status_s2 <= status_c;
		end
	end

	assign m_axis_tvalid = vld_s2;
	assign m_axis_tuser  = status_s2;
	assign m_axis_tdata  = (status_s2 == ST_SYMBOL) ? ram_rdata : '0;

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Canonical Huffman bit decoder testbench
// Builds code tables from add beats and feeds coded bit streams through the
// decoder. Each accepted input beat is run through an in-bench table model,
// and every result beat is checked against the oldest outstanding prediction.
// ----------------------------------------------------------------------------

module testbench;
	import chbd_pkg::*;

	localparam int MAX_LEN     = 16;
	localparam int MAX_SYMS    = 256;
	localparam int STALL_LIMIT = 2000;
	localparam int RAND_BEATS  = 1250;

	typedef struct {
		op_t        op;
		logic [4:0] len;
		sym_t       sym;
		logic       bit_val;
		int         gap;
		bit         drain;
	} beat_t;

	typedef struct packed {
		status_t status;
		sym_t    sym;
	} result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic [2:0]  m_axis_tuser;

	canonical_huffman_bit_decoder u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Table model state, updated once per accepted input beat.
	logic [63:0] tbl_first [MAX_LEN];
	int          tbl_count [MAX_LEN];
	int          tbl_base  [MAX_LEN];
	sym_t        tbl_syms  [MAX_SYMS];
	int          tbl_total;
	int          tbl_last;
	logic [63:0] tbl_next;
	logic [63:0] dec_prefix;
	int          dec_len;

	beat_t   pending_beats [$];
	result_t results_due [$];

	// Stimulus-side view of the table, used only to know which codes exist.
	logic [63:0] gen_codes [$];
	int          gen_lens [$];
	logic [63:0] gen_next;
	int          gen_last;
	int          gen_total;

	bit in_calm = 1'b0;
	bit out_calm = 1'b0;
	bit next_drain = 1'b0;
	int n_pushed = 0;
	int in_wait = 0;
	int out_stall = 0;
	int idle_cycles = 0;
	bit in_fire = 1'b0;
	bit out_fire = 1'b0;

	int errors = 0;
	int n_accepted = 0;
	int n_checked = 0;
	int n_symbols = 0;
	int n_dec_errors = 0;
	int n_add_ok = 0;
	int n_add_bad = 0;

	task automatic to_root();
		dec_prefix = '0;
		dec_len = 0;
	endtask

	task automatic huff_predict(input op_t op, input logic [4:0] len_f, input sym_t sym_i,
			input logic bit_i, output result_t res);
		logic [63:0] code;
		int len;
		int k;
		len = int'(len_f);
		res.status = ST_PENDING;
		res.sym = '0;
		case (op)
		OP_ADD: begin
			res.status = ST_ADD_BAD;
			if (len != 0 && len <= MAX_LEN && len >= tbl_last && tbl_total < MAX_SYMS) begin
				code = tbl_next << (len - tbl_last);
				if (code < (64'd1 << len)) begin
					k = len - 1;
					if (tbl_count[k] == 0) begin
						tbl_first[k] = code;
						tbl_base[k] = tbl_total;
					end
					tbl_syms[tbl_total] = sym_i;
					tbl_count[k]++;
					tbl_total++;
					tbl_next = code + 1;
					tbl_last = len;
					res.status = ST_ADD_OK;
				end
			end
		end
		OP_DECODE: begin
			if (tbl_total == 0 || dec_len >= MAX_LEN) begin
				res.status = ST_ERROR;
			end else begin
				dec_prefix = {dec_prefix[62:0], bit_i};
				dec_len++;
				k = dec_len - 1;
				res.status = ST_ERROR;
				if (tbl_count[k] != 0 && dec_prefix >= tbl_first[k] &&
						dec_prefix - tbl_first[k] < tbl_count[k]) begin
					res.sym = tbl_syms[tbl_base[k] + int'(dec_prefix - tbl_first[k])];
					res.status = ST_SYMBOL;
				end else if (dec_len < tbl_last &&
						(dec_prefix << (tbl_last - dec_len)) < tbl_next) begin
					res.status = ST_PENDING;
				end
			end
			if (res.status != ST_PENDING)
				to_root();
		end
		OP_CLEAR: begin
			for (int i = 0; i < MAX_LEN; i++) begin
				tbl_first[i] = '0;
				tbl_count[i] = 0;
				tbl_base[i] = 0;
			end
			tbl_total = 0;
			tbl_last = 0;
			tbl_next = '0;
			to_root();
		end
		default: begin
			to_root();
		end
		endcase
	endtask

	task automatic push(input op_t op, input int len, input sym_t s, input logic b);
		beat_t t;
		t.op = op;
		t.len = len[4:0];
		t.sym = s;
		t.bit_val = b;
		t.gap = in_calm ? 0 : $urandom_range(0, 3);
		t.drain = next_drain;
		next_drain = 1'b0;
		if ($urandom_range(0, 99) == 0)
			in_calm = !in_calm;
		pending_beats = {pending_beats, t};
		n_pushed++;
	endtask

	task automatic push_bit(input logic b);
		push(OP_DECODE, $urandom_range(0, 31), sym_t'($urandom_range(0, 255)), b);
	endtask

	task automatic push_ctl(input op_t op);
		push(op, $urandom_range(0, 31), sym_t'($urandom_range(0, 255)),
			1'($urandom_range(0, 1)));
	endtask

	task automatic gen_clear();
		push_ctl(OP_CLEAR);
		gen_next = '0;
		gen_last = 0;
		gen_total = 0;
		gen_codes.delete();
		gen_lens.delete();
	endtask

	task automatic gen_add(input int len, input sym_t s);
		logic [63:0] code;
		push(OP_ADD, len, s, 1'($urandom_range(0, 1)));
		if (len >= 1 && len <= MAX_LEN && len >= gen_last && gen_total < MAX_SYMS) begin
			code = gen_next << (len - gen_last);
			if (code < (64'd1 << len)) begin
				gen_codes = {gen_codes, code};
				gen_lens = {gen_lens, len};
				gen_next = code + 1;
				gen_last = len;
				gen_total++;
			end
		end
	endtask

	task automatic push_code(input int k);
		for (int i = gen_lens[k] - 1; i >= 0; i--)
			push_bit(gen_codes[k][i]);
	endtask

	// Table of short random size followed by a burst of mostly valid code words,
	// with noise, restarts and adds cutting into the middle of words.
	task automatic random_table();
		int n_add;
		int n_word;
		int cur;
		int r;
		int k;
		int len;
		int cut;
		if ($urandom_range(0, 7) == 0)
			next_drain = 1'b1;
		if ($urandom_range(0, 5) != 0)
			gen_clear();
		n_add = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
		cur = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 16) : $urandom_range(1, 5);
		repeat (n_add) begin
			r = $urandom_range(0, 19);
			if (r == 0) begin
				gen_add($urandom_range(0, 1) ? 0 : $urandom_range(17, 31),
					sym_t'($urandom_range(0, 255)));
			end else if (r == 1 && gen_last > 1) begin
				gen_add($urandom_range(1, gen_last - 1), sym_t'($urandom_range(0, 255)));
			end else begin
				if (cur < MAX_LEN && $urandom_range(0, 2) == 0)
					cur = cur + $urandom_range(1, (MAX_LEN - cur < 3) ? MAX_LEN - cur : 3);
				gen_add(cur, sym_t'($urandom_range(0, 255)));
			end
		end
		n_word = $urandom_range(3, 20);
		repeat (n_word) begin
			r = $urandom_range(0, 15);
			if (gen_codes.size() == 0 || r == 0) begin
				repeat ($urandom_range(1, 6)) push_bit(1'($urandom_range(0, 1)));
			end else if (r == 1) begin
				push_ctl(OP_RESTART);
			end else begin
				k = $urandom_range(0, gen_codes.size() - 1);
				len = gen_lens[k];
				cut = $urandom_range(1, len);
				for (int i = 0; i < len; i++) begin
					if (i == cut && r == 2) begin
						push_ctl(OP_RESTART);
						break;
					end
					if (i == cut && r == 3)
						gen_add((gen_last == 0) ? 1 : gen_last,
							sym_t'($urandom_range(0, 255)));
					push_bit(gen_codes[k][len - 1 - i]);
				end
			end
		end
	endtask

	// Fills the store to its symbol limit, tries two more adds, then decodes the last code and nine random ones.
	task automatic full_table();
		next_drain = 1'b1;
		gen_clear();
		repeat (MAX_SYMS) gen_add(9, sym_t'($urandom_range(0, 255)));
		gen_add(9, sym_t'($urandom_range(0, 255)));
		gen_add(MAX_LEN, sym_t'($urandom_range(0, 255)));
		push_code(MAX_SYMS - 1);
		repeat (9) push_code($urandom_range(0, MAX_SYMS - 1));
	endtask

	// Sampling, prediction, checking and the watchdog, all at the rising edge.
	always @(posedge clk) begin
		result_t res;
		result_t want;
		in_fire <= arst_n && s_axis_tvalid && s_axis_tready;
		out_fire <= arst_n && m_axis_tvalid && m_axis_tready;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (results_due.size() == 0) begin
					$error("result beat with nothing outstanding: status %0d symbol_out %0d",
						m_axis_tuser, m_axis_tdata);
					errors++;
				end else begin
					want = results_due.pop_front();
					n_checked++;
					if (m_axis_tuser !== want.status) begin
						$error("status mismatch: expected %0d, actual %0d", want.status, m_axis_tuser);
						errors++;
					end
					if (m_axis_tdata !== want.sym) begin
						$error("symbol_out mismatch: expected %0d, actual %0d", want.sym, m_axis_tdata);
						errors++;
					end
					case (want.status)
					ST_SYMBOL:  n_symbols++;
					ST_ERROR:   n_dec_errors++;
					ST_ADD_OK:  n_add_ok++;
					ST_ADD_BAD: n_add_bad++;
					default: ;
					endcase
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				huff_predict(op_t'(s_axis_tuser), s_axis_tdata[4:0], s_axis_tdata[12:5],
					s_axis_tdata[13], res);
				results_due = {results_due, res};
				n_accepted++;
			end
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
				$display("testbench failed");
				$finish;
			end
		end
	end

	// Input driver: one beat at a time from the pending queue, with per-beat gaps.
	always @(negedge clk) begin
		logic hold;
		hold = s_axis_tvalid && !in_fire;
		if (arst_n && !hold && pending_beats.size() != 0) begin
			if (!(pending_beats[0].drain && results_due.size() != 0)) begin
				if (in_wait < pending_beats[0].gap) begin
					in_wait++;
				end else begin
					beat_t t;
					t = pending_beats.pop_front();
					s_axis_tdata <= {2'b00, t.bit_val, t.sym, t.len};
					s_axis_tuser <= t.op;
					in_wait = 0;
					hold = 1'b1;
				end
			end
		end
		s_axis_tvalid <= hold;
	end

	// Result side back-pressure, drawn per accepted result beat.
	always @(negedge clk) begin
		if (out_fire)
			out_stall = out_calm ? 0 : $urandom_range(0, 3);
		if ($urandom_range(0, 299) == 0)
			out_calm = !out_calm;
		if (out_stall > 0) begin
			m_axis_tready <= 1'b0;
			out_stall--;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	initial begin
		int n_directed;
		bit full_done;
		result_t init_res;
		huff_predict(OP_CLEAR, '0, '0, 1'b0, init_res);
		gen_next = '0;
		gen_last = 0;
		gen_total = 0;
		full_done = 1'b0;

		// Directed opening: empty table, bad lengths, the order rule, short codes,
		// a dead prefix, restart and an add in mid word.
		push_bit(1'b1);
		gen_add(0, 8'h12);
		gen_add(17, 8'h34);
		gen_add(31, 8'h56);
		gen_add(1, 8'h00);
		gen_add(2, 8'hFF);
		gen_add(1, 8'h33);
		gen_add(3, 8'hA5);
		push_bit(1'b0);
		push_bit(1'b1);
		push_bit(1'b0);
		push_bit(1'b1);
		push_bit(1'b1);
		push_bit(1'b0);
		push_bit(1'b1);
		push_bit(1'b1);
		push_bit(1'b1);
		push_bit(1'b1);
		push_ctl(OP_RESTART);
		push_bit(1'b0);
		push_bit(1'b1);
		gen_add(4, 8'h5A);
		push_bit(1'b1);
		push_bit(1'b1);
		push_bit(1'b0);
		next_drain = 1'b1;
		gen_add(MAX_LEN, 8'hC3);
		gen_clear();
		push_bit(1'b0);
		n_directed = n_pushed;

		while (n_pushed < n_directed + RAND_BEATS) begin
			if (!full_done && n_pushed > n_directed + RAND_BEATS / 2) begin
				full_table();
				full_done = 1'b1;
			end else begin
				random_table();
			end
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_beats.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (results_due.size() != 0) begin
			$error("%0d predicted results never arrived", results_due.size());
			errors++;
		end
		$display("Ran %0d input beats and checked %0d results: %0d symbols, %0d decode errors,",
			n_accepted, n_checked, n_symbols, n_dec_errors);
		$display("%0d adds taken and %0d adds refused, with %0d mismatches.",
			n_add_ok, n_add_bad, errors);
		if (errors == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/chbd_pkg.sv
rtl/chbd_ram.sv
rtl/canonical_huffman_bit_decoder.sv
tb/testbench.sv
